### src/ring_radial_alpha_shader_assert.svh
// assertion macros used by the shader module
`ifndef RING_RADIAL_ALPHA_SHADER_ASSERT_SVH
`define RING_RADIAL_ALPHA_SHADER_ASSERT_SVH

// same-cycle implication
`define RRAS_ASSERT_NOW(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("shader assertion failed");

// next-cycle implication
`define RRAS_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("shader assertion failed");

`endif

### src/rras_pkg.sv
`timescale 1ns / 1ps
package rras_pkg;
	localparam int DIST_FRAC_BITS = 8;
	localparam int RAD_W = 9;
	localparam int COORD_W = 11;
	localparam int SQ_W = 21;
	localparam int ROOT_W = 19;
	localparam int DEN_W = 17;
	localparam int DEN2_W = 34;
	localparam int NUM_W = 42;
	localparam int Q_W = 8;

	localparam logic [2:0] REG_INNER_RADIUS = 3'd0;
	localparam logic [2:0] REG_RING_WIDTH = 3'd1;
	localparam logic [2:0] REG_FILL_RGB = 3'd2;
	localparam logic [2:0] REG_ALPHA_INNER = 3'd3;
	localparam logic [2:0] REG_ALPHA_OUTER = 3'd4;
	localparam logic [2:0] REG_PROFILE_MODE = 3'd5;

	localparam logic [1:0] MODE_INV_SQ = 2'd1;
	localparam logic [1:0] MODE_LINEAR = 2'd2;

	localparam logic [1:0] KIND_DIV = 2'd0;
	localparam logic [1:0] KIND_AI = 2'd1;
	localparam logic [1:0] KIND_AO = 2'd2;

	typedef struct packed {
		logic ring;
		logic [1:0] kind;
	} div_side_t;
endpackage

### src/rras_sqrt.sv
`timescale 1ns / 1ps
module rras_sqrt (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [rras_pkg::SQ_W-1:0] in_sq,
	input logic in_side,
	output logic out_valid,
	output logic [rras_pkg::ROOT_W-1:0] out_root,
	output logic out_side
);
	localparam int N = rras_pkg::ROOT_W;
	localparam int RW = 2 * N;
	localparam int REMW = N + 2;

	logic v_q [0:N];
	logic side_q [0:N];
	logic [RW-1:0] rad_q [0:N];
	logic [REMW-1:0] rem_q [0:N];
	logic [N-1:0] root_q [0:N];

	// root of sq scaled by 2^(2*frac)
	assign v_q[0] = in_valid;
	assign side_q[0] = in_side;
	assign rad_q[0] = RW'({in_sq, {(2 * rras_pkg::DIST_FRAC_BITS){1'b0}}});
	assign rem_q[0] = '0;
	assign root_q[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [REMW+1:0] rem_sh;
		logic [REMW+1:0] trial;
		logic take;

		always_comb begin
			rem_sh = {rem_q[i], rad_q[i][RW-1 -: 2]};
			trial = (REMW+2)'({root_q[i], 2'b01});
			take = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i+1] <= side_q[i];
				rad_q[i+1] <= {rad_q[i][RW-3:0], 2'b00};
				rem_q[i+1] <= take ? REMW'(rem_sh - trial) : REMW'(rem_sh);
				root_q[i+1] <= {root_q[i][N-2:0], take};
			end
		end
	end

	assign out_valid = v_q[N];
	assign out_root = root_q[N];
	assign out_side = side_q[N];
endmodule

### src/rras_div.sv
`timescale 1ns / 1ps
module rras_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [rras_pkg::NUM_W-1:0] in_num,
	input logic [rras_pkg::DEN2_W-1:0] in_den,
	input rras_pkg::div_side_t in_side,
	output logic out_valid,
	output logic [rras_pkg::Q_W-1:0] out_quot,
	output rras_pkg::div_side_t out_side
);
	localparam int N = rras_pkg::Q_W;
	localparam int NW = rras_pkg::NUM_W;
	localparam int DW = rras_pkg::DEN2_W;

	logic v_q [0:N];
	rras_pkg::div_side_t side_q [0:N];
	logic [NW-1:0] rem_q [0:N];
	logic [DW-1:0] den_q [0:N];
	logic [N-1:0] quot_q [0:N];

	assign v_q[0] = in_valid;
	assign side_q[0] = in_side;
	assign rem_q[0] = in_num;
	assign den_q[0] = in_den;
	assign quot_q[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [NW-1:0] dsh;
		logic take;

		always_comb begin
			dsh = NW'(den_q[k]) << (N - 1 - k);
			take = rem_q[k] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k+1] <= side_q[k];
				den_q[k+1] <= den_q[k];
				rem_q[k+1] <= take ? rem_q[k] - dsh : rem_q[k];
				quot_q[k+1] <= {quot_q[k][N-2:0], take};
			end
		end
	end

	assign out_valid = v_q[N];
	assign out_quot = quot_q[N];
	assign out_side = side_q[N];
endmodule

### src/ring_radial_alpha_shader.sv
`timescale 1ns / 1ps
// stages: offsets, squared distance, root, ring test, squares, products, numerator, quotient, output register
// throughput: one pixel per cycle while the output is not stalled; pipeline of 19 root stages and 8 quotient stages
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: arst_n clears all valid bits; registers return to inner 0, width 16,
// fill white, inner alpha 255, outer alpha 0, quadratic profile
`include "ring_radial_alpha_shader_assert.svh"
module ring_radial_alpha_shader (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata, // pixel_x, pixel_y, zero pad
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // red, green, blue, alpha
	output logic m_tuser, // inside_ring
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data
);
	localparam int F = rras_pkg::DIST_FRAC_BITS;
	localparam int DW = rras_pkg::DEN_W;
	localparam int D2W = rras_pkg::DEN2_W;
	localparam int NW = rras_pkg::NUM_W;

	logic [rras_pkg::RAD_W-1:0] inner_q, width_q;
	logic [23:0] rgb_q;
	logic [7:0] ai_q, ao_q;
	logic [1:0] mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			width_q <= 9'd16;
			rgb_q <= 24'hFFFFFF;
			ai_q <= 8'd255;
			ao_q <= 8'd0;
			mode_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rras_pkg::REG_INNER_RADIUS: inner_q <= cfg_data[8:0];
				rras_pkg::REG_RING_WIDTH: width_q <= cfg_data[8:0];
				rras_pkg::REG_FILL_RGB: rgb_q <= cfg_data;
				rras_pkg::REG_ALPHA_INNER: ai_q <= cfg_data[7:0];
				rras_pkg::REG_ALPHA_OUTER: ao_q <= cfg_data[7:0];
				rras_pkg::REG_PROFILE_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [9:0] rout;
	logic [10:0] px, py;
	assign rout = 10'(inner_q) + 10'(width_q);
	assign px = s_tdata[10:0];
	assign py = s_tdata[21:11];

	// stage 1: offsets from the center
	logic v_s1, spr_s1;
	logic [9:0] dx_s1, dy_s1;
	// stage 2: squared distance
	logic v_s2, spr_s2;
	logic [rras_pkg::SQ_W-1:0] sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spr_s1 <= (px < {rout, 1'b0}) && (py < {rout, 1'b0});
			dx_s1 <= px >= 11'(rout) ? 10'(px - 11'(rout)) : 10'(11'(rout) - px);
			dy_s1 <= py >= 11'(rout) ? 10'(py - 11'(rout)) : 10'(11'(rout) - py);
			spr_s2 <= spr_s1;
			sq_s2 <= rras_pkg::SQ_W'(20'(dx_s1) * 20'(dx_s1))
				+ rras_pkg::SQ_W'(20'(dy_s1) * 20'(dy_s1));
		end
	end

	logic vq;
	logic sprq;
	logic [rras_pkg::ROOT_W-1:0] dist_fx;

	rras_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s2),
		.in_sq(sq_s2),
		.in_side(spr_s2),
		.out_valid(vq),
		.out_root(dist_fx),
		.out_side(sprq)
	);

	logic [DW-1:0] lo, dfull;
	logic [DW:0] hi;
	assign lo = {inner_q, {F{1'b0}}};
	assign dfull = {width_q, {F{1'b0}}};
	assign hi = {rout, {F{1'b0}}};

	// stage 3: ring test
	logic v_s3, ring_s3;
	logic [DW-1:0] n_s3;
	// stage 4: squares
	logic v_s4, ring_s4;
	logic [DW-1:0] n_s4, dn_s4;
	logic [D2W-1:0] nn_s4, dd_s4, d2_s4;
	// stage 5: weighted products
	logic v_s5;
	rras_pkg::div_side_t side_s5;
	logic [NW-1:0] pa_s5, pb_s5;
	logic [D2W-1:0] den_s5;
	// stage 6: numerator
	logic v_s6;
	rras_pkg::div_side_t side_s6;
	logic [NW-1:0] num_s6;
	logic [D2W-1:0] den_s6;

	logic [D2W-1:0] g, opa, opb;
	always_comb begin
		g = (mode_q == rras_pkg::MODE_INV_SQ) ? d2_s4 - nn_s4 : dd_s4;
		if (mode_q == rras_pkg::MODE_LINEAR) begin
			opa = D2W'(dn_s4);
			opb = D2W'(n_s4);
		end else begin
			opa = g;
			opb = d2_s4 - g;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s3 <= vq;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s3 <= sprq && (dist_fx >= rras_pkg::ROOT_W'(lo))
				&& (dist_fx <= rras_pkg::ROOT_W'(hi));
			n_s3 <= DW'(dist_fx - rras_pkg::ROOT_W'(lo));
			ring_s4 <= ring_s3;
			n_s4 <= n_s3;
			dn_s4 <= dfull - n_s3;
			nn_s4 <= D2W'(n_s3) * D2W'(n_s3);
			dd_s4 <= D2W'(dfull - n_s3) * D2W'(dfull - n_s3);
			d2_s4 <= D2W'(dfull) * D2W'(dfull);
			side_s5.ring <= ring_s4;
			if (ai_q == ao_q) begin
				side_s5.kind <= rras_pkg::KIND_AO;
			end else if (width_q == '0) begin
				side_s5.kind <= rras_pkg::KIND_AI;
			end else begin
				side_s5.kind <= rras_pkg::KIND_DIV;
			end
			pa_s5 <= NW'(ai_q) * NW'(opa);
			pb_s5 <= NW'(ao_q) * NW'(opb);
			den_s5 <= (mode_q == rras_pkg::MODE_LINEAR) ? D2W'(dfull) : d2_s4;
			side_s6 <= side_s5;
			num_s6 <= pa_s5 + pb_s5;
			den_s6 <= den_s5;
		end
	end

	logic vd;
	logic [7:0] quot;
	rras_pkg::div_side_t sided;

	rras_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s6),
		.in_num(num_s6),
		.in_den(den_s6),
		.in_side(side_s6),
		.out_valid(vd),
		.out_quot(quot),
		.out_side(sided)
	);

	logic [7:0] alpha_sel;
	always_comb begin
		case (sided.kind)
			rras_pkg::KIND_AO: alpha_sel = ao_q;
			rras_pkg::KIND_AI: alpha_sel = ai_q;
			default: alpha_sel = quot;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= sided.ring;
			if (sided.ring) begin
				m_tdata <= {alpha_sel, rgb_q[7:0], rgb_q[15:8], rgb_q[23:16]};
			end else begin
				m_tdata <= '0;
			end
		end
	end

	`RRAS_ASSERT_NOW(a_outside_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0)
	`RRAS_ASSERT_NOW(a_ring_offset, clk, arst_n, v_s3 && ring_s3, n_s3 <= dfull)
	`RRAS_ASSERT_NOW(a_alpha_bounded, clk, arst_n, m_tvalid && m_tuser, (m_tdata[31:24] >= ai_q || m_tdata[31:24] >= ao_q) && (m_tdata[31:24] <= ai_q || m_tdata[31:24] <= ao_q))
endmodule
